// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the block's RTL files.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error(msg);

`endif

// ===== rtl/srit_pkg.sv =====
// Types and codes for the sorted record table.
// Used by the controller, the datapath and the top level; depends on nothing.
package srit_pkg;

	localparam logic [1:0] CMD_INSERT     = 2'd0;
	localparam logic [1:0] CMD_LIST_ALL   = 2'd1;
	localparam logic [1:0] CMD_LIST_OWING = 2'd2;
	localparam logic [1:0] CMD_UNUSED     = 2'd3;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_LISTED   = 2'd2;
	localparam logic [1:0] ST_NONE     = 2'd3;

	typedef struct packed {
		logic [1:0]         command;
		logic [15:0]        member_id;
		logic [22:0]        deposit_cents;
		logic signed [23:0] balance_cents;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        entry_id;
		logic [22:0]        entry_deposit;
		logic signed [23:0] entry_balance;
		logic               last;
	} rsp_item_t;

	typedef struct packed {
		logic [15:0]        id;
		logic [22:0]        deposit;
		logic signed [23:0] balance;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic       load_new;
		logic       hold_clear;
		logic       hold_load;
		logic       wr_en;
		logic       wr_sel_new;
		logic       rd_en;
		logic       count_inc;
		logic       out_load;
		logic       out_sel_hold;
		logic [1:0] out_status;
		logic       out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic entry_gt_new;
		logic entry_pos;
		logic hold_valid;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== rtl/srit_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module srit_ram #(
	parameter int WIDTH = 63,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/srit_datapath.sv =====
// Datapath of the sorted record table: record RAM, entry count, new record,
// hold buffer and output register. Depends on srit_pkg and srit_ram.
module srit_datapath #(
	parameter int CAPACITY = 64,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  srit_pkg::req_item_t req,
	input  srit_pkg::dp_cmd_t   cmd,
	input  logic [AW-1:0]       wr_addr,
	input  logic [AW-1:0]       rd_addr,
	output srit_pkg::dp_sts_t   sts,
	output logic [CW-1:0]       count,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output srit_pkg::rsp_item_t rsp
);
	import srit_pkg::*;

	logic [CW-1:0]    count_q;
	rec_t             new_q;
	rec_t             hold_q;
	logic             hold_valid_q;
	logic             out_valid_q;
	rsp_item_t        out_q;
	logic [REC_W-1:0] ram_rd;
	rec_t             rd_rec;
	rec_t             wr_rec;

	assign rd_rec = rec_t'(ram_rd);
	assign wr_rec = cmd.wr_sel_new ? new_q : rd_rec;

	srit_ram #(
		.WIDTH(REC_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_rec),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.hold_clear) begin
				hold_valid_q <= 1'b0;
			end else if (cmd.hold_load) begin
				hold_valid_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_new) begin
			new_q.id      <= req.member_id;
			new_q.deposit <= req.deposit_cents;
			new_q.balance <= req.balance_cents;
		end
		if (cmd.hold_load) begin
			hold_q <= rd_rec;
		end
		if (cmd.out_load) begin
			out_q.status <= cmd.out_status;
			out_q.last   <= cmd.out_last;
			if (cmd.out_sel_hold) begin
				out_q.entry_id      <= hold_q.id;
				out_q.entry_deposit <= hold_q.deposit;
				out_q.entry_balance <= hold_q.balance;
			end else begin
				out_q.entry_id      <= '0;
				out_q.entry_deposit <= '0;
				out_q.entry_balance <= '0;
			end
		end
	end

	assign sts.full         = (count_q == CW'(CAPACITY));
	assign sts.empty        = (count_q == '0);
	assign sts.entry_gt_new = ($signed(rd_rec.balance) > $signed(new_q.balance));
	assign sts.entry_pos    = ($signed(rd_rec.balance) > 24'sd0);
	assign sts.hold_valid   = hold_valid_q;
	assign sts.out_free     = !out_valid_q || !rsp_stall;

	assign count     = count_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ===== rtl/srit_ctrl.sv =====
// Controller of the sorted record table: sequences insert scans and list walks.
// Depends on srit_pkg; drives the datapath through dp_cmd_t and RAM addresses.
module srit_ctrl #(
	parameter int CAPACITY = 64,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_command,
	output logic              req_stall,
	input  srit_pkg::dp_sts_t sts,
	input  logic [CW-1:0]     count,
	output srit_pkg::dp_cmd_t cmd,
	output logic [AW-1:0]     wr_addr,
	output logic [AW-1:0]     rd_addr
);
	import srit_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_START,
		S_INS_SCAN,
		S_INS_FIRST,
		S_LST_START,
		S_LST_SCAN,
		S_LST_FLUSH,
		S_EMIT
	} state_t;

	state_t        state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic          list_all_q, list_all_d;
	logic [1:0]    emit_st_q, emit_st_d;
	logic          qual;
	logic          consume;

	assign qual    = list_all_q || sts.entry_pos;
	assign consume = !qual || !sts.hold_valid || sts.out_free;

	always_comb begin
		cmd        = '0;
		wr_addr    = idx_q + AW'(1);
		rd_addr    = '0;
		state_d    = state_q;
		idx_d      = idx_q;
		ptr_d      = ptr_q;
		list_all_d = list_all_q;
		emit_st_d  = emit_st_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_new   = 1'b1;
					cmd.hold_clear = 1'b1;
					unique case (req_command)
						CMD_INSERT: begin
							state_d = S_INS_START;
						end
						CMD_LIST_ALL: begin
							list_all_d = 1'b1;
							state_d    = S_LST_START;
						end
						CMD_LIST_OWING: begin
							list_all_d = 1'b0;
							state_d    = S_LST_START;
						end
						default: begin
						end
					endcase
				end
			end
			S_INS_START: begin
				if (sts.full) begin
					emit_st_d = ST_FULL;
					state_d   = S_EMIT;
				end else if (sts.empty) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_sel_new = 1'b1;
					cmd.count_inc  = 1'b1;
					wr_addr        = '0;
					emit_st_d      = ST_INSERTED;
					state_d        = S_EMIT;
				end else begin
					cmd.rd_en = 1'b1;
					rd_addr   = AW'(count - CW'(1));
					idx_d     = AW'(count - CW'(1));
					state_d   = S_INS_SCAN;
				end
			end
			S_INS_SCAN: begin
				cmd.wr_en = 1'b1;
				if (sts.entry_gt_new) begin
					if (idx_q == '0) begin
						state_d = S_INS_FIRST;
					end else begin
						cmd.rd_en = 1'b1;
						rd_addr   = idx_q - AW'(1);
						idx_d     = idx_q - AW'(1);
					end
				end else begin
					cmd.wr_sel_new = 1'b1;
					cmd.count_inc  = 1'b1;
					emit_st_d      = ST_INSERTED;
					state_d        = S_EMIT;
				end
			end
			S_INS_FIRST: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_sel_new = 1'b1;
				cmd.count_inc  = 1'b1;
				wr_addr        = '0;
				emit_st_d      = ST_INSERTED;
				state_d        = S_EMIT;
			end
			S_LST_START: begin
				if (sts.empty) begin
					emit_st_d = ST_NONE;
					state_d   = S_EMIT;
				end else begin
					cmd.rd_en = 1'b1;
					rd_addr   = '0;
					ptr_d     = CW'(1);
					state_d   = S_LST_SCAN;
				end
			end
			S_LST_SCAN: begin
				if (consume) begin
					if (qual) begin
						cmd.hold_load = 1'b1;
						if (sts.hold_valid) begin
							cmd.out_load     = 1'b1;
							cmd.out_sel_hold = 1'b1;
							cmd.out_status   = ST_LISTED;
						end
					end
					if (ptr_q != count) begin
						cmd.rd_en = 1'b1;
						rd_addr   = ptr_q[AW-1:0];
						ptr_d     = ptr_q + CW'(1);
					end else if (sts.hold_valid || qual) begin
						state_d = S_LST_FLUSH;
					end else begin
						emit_st_d = ST_NONE;
						state_d   = S_EMIT;
					end
				end
			end
			S_LST_FLUSH: begin
				if (sts.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_sel_hold = 1'b1;
					cmd.out_status   = ST_LISTED;
					cmd.out_last     = 1'b1;
					state_d          = S_IDLE;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = emit_st_q;
					cmd.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			ptr_q      <= '0;
			list_all_q <= 1'b0;
			emit_st_q  <= ST_NONE;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			ptr_q      <= ptr_d;
			list_all_q <= list_all_d;
			emit_st_q  <= emit_st_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

// ===== rtl/sorted_insert_record_table.sv =====
// Sorted record table. A request transfer on req carries a command and a record.
// Insert places the record after every entry whose balance is less than or equal
// to its own and answers with one result: inserted, or full when the table holds
// CAPACITY entries. List-all streams every entry in balance order; list-owing
// streams only entries with a positive balance; a list with nothing to give
// answers with one nothing-to-list result. The final result of a request has
// last set. Command 3 is taken and answered with nothing.
// An insert scan moves one entry per cycle through the record RAM's single read
// port, from the last entry down to the insert position. A list walks the
// entries one per cycle while rsp is not stalled; list-all then gives one result
// per cycle, and list-owing gives none for an entry that does not qualify.
// req_stall is high from a request transfer with a result until its last result is in the
// output register; the next request is taken while that result still waits.
// rsp_stall holds the output register and pauses a list walk without loss.
// Reset empties the table at once; no clearing pass runs.
// Depends on srit_pkg, srit_ctrl, srit_datapath, srit_ram and assert_macros.svh.
`include "assert_macros.svh"

module sorted_insert_record_table #(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  srit_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output srit_pkg::rsp_item_t rsp
);
	import srit_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	dp_cmd_t       ctl_cmd;
	dp_sts_t       dp_sts;
	logic [CW-1:0] dp_count;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	srit_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_command(req.command),
		.req_stall  (req_stall),
		.sts        (dp_sts),
		.count      (dp_count),
		.cmd        (ctl_cmd),
		.wr_addr    (wr_addr),
		.rd_addr    (rd_addr)
	);

	srit_datapath #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (ctl_cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.sts      (dp_sts),
		.count    (dp_count),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	`ASSERT_HOLDS(a_busy_after_cmd, clk, arst_n, (req_valid && !req_stall && req.command != CMD_UNUSED) |=> req_stall, "request with a result did not hold off the next request")
	`ASSERT_HOLDS(a_count_bound, clk, arst_n, dp_count <= CW'(CAPACITY), "entry count exceeds capacity")
	`ASSERT_HOLDS(a_single_last, clk, arst_n, (rsp_valid && rsp.status != ST_LISTED) |-> rsp.last, "single result without last")
	`ASSERT_NEVER(a_idle_write, clk, arst_n, ctl_cmd.wr_en && !req_stall, "record RAM written while idle")

endmodule
